// ===== rtl/core/doeq_pkg.sv =====
// ----------------------------------------------------------------------------
// doeq_pkg
// Shared types and codes for the deadline-ordered event queue.
// ----------------------------------------------------------------------------
package doeq_pkg;

    localparam int ID_BITS     = 4;
    localparam int STATUS_BITS = 3;
    localparam int OCC_BITS    = 5;

    // most entries one dispatch may release
    localparam int MAX_RESULTS    = 16;
    localparam int DISP_CNT_BITS  = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        REQ_ENQUEUE  = 2'd0,
        REQ_CANCEL   = 2'd1,
        REQ_DISPATCH = 2'd2,
        REQ_FLUSH    = 2'd3
    } req_e;

    localparam logic [STATUS_BITS-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_DUP      = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_NOTFOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_NONEDUE  = 3'd4;

    // command broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_POP    = 2'd3
    } cell_op_t;

endpackage

// ===== rtl/core/doeq_cell.sv =====
// ----------------------------------------------------------------------------
// doeq_cell
// One slot of the sorted row: holds a handle and its deadline, compares them
// with the broadcast key and shifts left or right with its neighbours.
// ----------------------------------------------------------------------------
module doeq_cell #(
    parameter int TIME_BITS = 48
) (
    input  logic                          aclk,
    input  doeq_pkg::cell_op_t            op,
    input  logic                          occupied,
    input  logic [doeq_pkg::ID_BITS-1:0]  key_id,
    input  logic [TIME_BITS-1:0]          key_time,
    input  logic [doeq_pkg::ID_BITS-1:0]  new_id,
    input  logic [TIME_BITS-1:0]          new_time,
    input  logic                          left_le,
    input  logic                          left_hit,
    input  logic [doeq_pkg::ID_BITS-1:0]  left_id,
    input  logic [TIME_BITS-1:0]          left_time,
    input  logic [doeq_pkg::ID_BITS-1:0]  right_id,
    input  logic [TIME_BITS-1:0]          right_time,
    output logic                          le,
    output logic                          hit,
    output logic [doeq_pkg::ID_BITS-1:0]  cell_id,
    output logic [TIME_BITS-1:0]          cell_time
);

    logic [doeq_pkg::ID_BITS-1:0] id_reg, id_next;
    logic [TIME_BITS-1:0]         time_reg, time_next;
    logic                         match;

    assign match     = occupied && (id_reg == key_id);
    assign le        = occupied && (time_reg <= key_time);
    // set from the matching slot rightwards: those slots close the gap
    assign hit       = left_hit | match;
    assign cell_id   = id_reg;
    assign cell_time = time_reg;

    always_comb begin
        id_next   = id_reg;
        time_next = time_reg;
        unique case (op)
            doeq_pkg::CELL_INSERT: begin
                if (!le) begin
                    if (left_le) begin
                        id_next   = new_id;
                        time_next = new_time;
                    end else begin
                        id_next   = left_id;
                        time_next = left_time;
                    end
                end
            end
            doeq_pkg::CELL_REMOVE: begin
                if (hit) begin
                    id_next   = right_id;
                    time_next = right_time;
                end
            end
            doeq_pkg::CELL_POP: begin
                id_next   = right_id;
                time_next = right_time;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        time_reg <= time_next;
    end

endmodule

// ===== rtl/core/deadline_ordered_event_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_ordered_event_queue
// Deadline-sorted queue of call handles built as a row of compare-and-shift
// cells.
// ----------------------------------------------------------------------------
// Enqueue, cancel and flush register their result in the execute state once
// the result output is free, and the block takes the next request once that
// result is registered. Dispatch passes through the execute state to select
// its key and then releases one entry per cycle while the result output is
// free, or gives the none-due result. Every cell compares its own deadline
// and handle with the broadcast key combinationally and the whole row shifts
// as the result is registered, so that full-width compare followed by the
// shift is the critical path. Slot contents need no clearing after reset;
// only the control state, entry count, release count and result valid are
// reset. A stalled result output holds the block until it is taken.
// ----------------------------------------------------------------------------
module deadline_ordered_event_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic [doeq_pkg::ID_BITS-1:0]      s_call_id,
    input  logic [TIME_BITS-1:0]              s_due_time,
    input  logic [TIME_BITS-1:0]              s_now_time,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [doeq_pkg::STATUS_BITS-1:0]  m_status,
    output logic [doeq_pkg::ID_BITS-1:0]      m_out_call_id,
    output logic [TIME_BITS-1:0]              m_out_time,
    output logic                              m_last,
    output logic [doeq_pkg::OCC_BITS-1:0]     m_occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDW   = doeq_pkg::ID_BITS;
    localparam int NW    = doeq_pkg::DISP_CNT_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DISP
    } state_t;

    state_t                         state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [NW-1:0]                  n_reg, n_next;

    doeq_pkg::req_e                 req_reg;
    logic [IDW-1:0]                 id_reg;
    logic [TIME_BITS-1:0]           due_reg;
    logic [TIME_BITS-1:0]           now_reg;

    logic                           m_valid_reg, m_valid_next;
    logic [doeq_pkg::STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic [IDW-1:0]                 m_id_reg, m_id_next;
    logic [TIME_BITS-1:0]           m_time_reg, m_time_next;
    logic                           m_last_reg, m_last_next;
    logic [doeq_pkg::OCC_BITS-1:0]  m_occ_reg, m_occ_next;

    doeq_pkg::cell_op_t             cell_op;
    logic [TIME_BITS-1:0]           key_time;
    logic                           out_free;
    logic                           more;

    logic [QUEUE_DEPTH-1:0]         occ;
    logic [QUEUE_DEPTH-1:0]         le;
    logic [QUEUE_DEPTH-1:0]         hit;
    logic [IDW-1:0]                 cell_id   [QUEUE_DEPTH];
    logic [TIME_BITS-1:0]           cell_time [QUEUE_DEPTH];

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_call_id = m_id_reg;
    assign m_out_time    = m_time_reg;
    assign m_last        = m_last_reg;
    assign m_occupancy   = m_occ_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign key_time = (state_reg == S_DISP) ? now_reg : due_reg;

    // ---- cell row ----
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        localparam int L = (gi == 0) ? 0 : gi - 1;
        localparam int R = (gi == QUEUE_DEPTH - 1) ? gi : gi + 1;

        assign occ[gi] = (count_reg > CNT_W'(gi));

        doeq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .aclk       (aclk),
            .op         (cell_op),
            .occupied   (occ[gi]),
            .key_id     (id_reg),
            .key_time   (key_time),
            .new_id     (id_reg),
            .new_time   (due_reg),
            .left_le    ((gi == 0) ? 1'b1 : le[L]),
            .left_hit   ((gi == 0) ? 1'b0 : hit[L]),
            .left_id    (cell_id[L]),
            .left_time  (cell_time[L]),
            .right_id   (cell_id[R]),
            .right_time (cell_time[R]),
            .le         (le[gi]),
            .hit        (hit[gi]),
            .cell_id    (cell_id[gi]),
            .cell_time  (cell_time[gi])
        );
    end

    // another due entry behind the head, and room for one more result
    assign more = (n_reg != NW'(doeq_pkg::MAX_RESULTS - 1)) && le[1];

    // ---- control ----
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        cell_op       = doeq_pkg::CELL_HOLD;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_id_next     = m_id_reg;
        m_time_next   = m_time_reg;
        m_last_next   = m_last_reg;
        m_occ_next    = m_occ_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (req_reg == doeq_pkg::REQ_DISPATCH) begin
                    state_next = S_DISP;
                    n_next     = '0;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = doeq_pkg::STATUS_OK;
                    m_id_next     = id_reg;
                    m_time_next   = '0;
                    m_last_next   = 1'b1;
                    unique case (req_reg)
                        doeq_pkg::REQ_ENQUEUE: begin
                            if (hit[QUEUE_DEPTH-1]) begin
                                m_status_next = doeq_pkg::STATUS_DUP;
                            end else if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                                m_status_next = doeq_pkg::STATUS_FULL;
                            end else begin
                                cell_op    = doeq_pkg::CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        doeq_pkg::REQ_CANCEL: begin
                            if (hit[QUEUE_DEPTH-1]) begin
                                cell_op    = doeq_pkg::CELL_REMOVE;
                                count_next = count_reg - CNT_W'(1);
                            end else begin
                                m_status_next = doeq_pkg::STATUS_NOTFOUND;
                            end
                        end
                        doeq_pkg::REQ_FLUSH: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                    m_occ_next = doeq_pkg::OCC_BITS'(count_next);
                    state_next = S_IDLE;
                end
            end
            S_DISP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (le[0]) begin
                        cell_op       = doeq_pkg::CELL_POP;
                        count_next    = count_reg - CNT_W'(1);
                        n_next        = n_reg + NW'(1);
                        m_status_next = doeq_pkg::STATUS_OK;
                        m_id_next     = cell_id[0];
                        m_time_next   = cell_time[0];
                        m_last_next   = !more;
                        if (!more) begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        // only reached before the first release
                        m_status_next = doeq_pkg::STATUS_NONEDUE;
                        m_id_next     = id_reg;
                        m_time_next   = '0;
                        m_last_next   = 1'b1;
                        state_next    = S_IDLE;
                    end
                    m_occ_next = doeq_pkg::OCC_BITS'(count_next);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
        end
        m_status_reg <= m_status_next;
        m_id_reg     <= m_id_next;
        m_time_reg   <= m_time_next;
        m_last_reg   <= m_last_next;
        m_occ_reg    <= m_occ_next;
        if (s_valid && s_ready) begin
            req_reg <= doeq_pkg::req_e'(s_req_type);
            id_reg  <= s_call_id;
            due_reg <= s_due_time;
            now_reg <= s_now_time;
        end
    end

    // ---- checks ----
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in progress");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_op == doeq_pkg::CELL_POP) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not lower the entry count");

    a_pop_from_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_op == doeq_pkg::CELL_POP) |-> (occ[0] && (cell_time[0] <= now_reg)))
        else $error("pop of an entry that is not due");

    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != doeq_pkg::STATUS_OK)) |-> m_last_reg)
        else $error("failure result not marked last");

endmodule
